### design/conv_dot_product_requantize_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the conv dot product requantize unit
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CONV_DOT_PRODUCT_REQUANTIZE_UNIT_MACROS_SVH
`define CONV_DOT_PRODUCT_REQUANTIZE_UNIT_MACROS_SVH

// same-cycle implication
`define CDPR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cdpr: same-cycle check failed");

// next-cycle implication
`define CDPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cdpr: next-cycle check failed");

`endif

### design/cdpr_pkg.sv
// ----------------------------------------------------------------------------
// cdpr_pkg
// Types and constants shared by the conv dot product requantize unit.
// ----------------------------------------------------------------------------
package cdpr_pkg;

  localparam int DATA_W        = 8;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int VEC_BITS      = 64;
  localparam int RES_W         = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 24;
  localparam int DEF_VEC_ELEMS = 8;
  localparam int DEF_ACC_WIDTH = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOOP_COUNT       = 3'd0,
    CFG_OUTPUT_COUNT     = 3'd1,
    CFG_RELU_ENABLE      = 3'd2,
    CFG_WEIGHT_FRAC_BITS = 3'd3,
    CFG_INPUT_FRAC_BITS  = 3'd4,
    CFG_OUTPUT_FRAC_BITS = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] loop_count;
    logic [23:0] output_count;
    logic        relu_enable;
    logic [3:0]  weight_frac_bits;
    logic [3:0]  input_frac_bits;
    logic [3:0]  output_frac_bits;
  } cfg_t;

endpackage

### design/cdpr_if.sv
// ----------------------------------------------------------------------------
// cdpr channel interfaces
// Valid/ready channels for operand beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface cdpr_in_if
  import cdpr_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [VEC_BITS-1:0]      act_vec;
  logic [VEC_BITS-1:0]      weight_vec;
  logic signed [DATA_W-1:0] bias_value;

  modport source (output valid, act_vec, weight_vec, bias_value, input ready);
  modport sink   (input valid, act_vec, weight_vec, bias_value, output ready);
endinterface

interface cdpr_out_if
  import cdpr_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] result_value;
  logic                    last_output;

  modport source (output valid, result_value, last_output, input ready);
  modport sink   (input valid, result_value, last_output, output ready);
endinterface

interface cdpr_cfg_if
  import cdpr_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### design/conv_dot_product_requantize_unit.sv
// ----------------------------------------------------------------------------
// conv_dot_product_requantize_unit
// Int8 convolution MAC for one output lane, with bias, rounding, saturation
// and optional ReLU.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                  | beat when
//  in_i    | in  | act_vec, weight_vec, bias_value          | valid & ready
//  out_o   | out | result_value, last_output                | valid & ready
//  cfg_i   | in  | index (register number), data            | valid & ready
//
//  One operand beat per cycle while in_i.ready holds, set by the lane
//  multipliers and the one accumulator add. After the beat that closes its
//  group, a result passes the lane, merge, accumulate and requantize
//  output registers. Reset clears all control state; registers take their
//  default values. A held result stalls the pipe one stage at a time;
//  in_i.ready drops only once every stage is full. cfg_i is always ready.
// ----------------------------------------------------------------------------
module conv_dot_product_requantize_unit
  import cdpr_pkg::*;
#(
  parameter int VEC_ELEMS = DEF_VEC_ELEMS,
  parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cdpr_in_if.sink    in_i,
  cdpr_out_if.source out_o,
  cdpr_cfg_if.sink   cfg_i
);

  localparam int SUM_W = PROD_W + $clog2(VEC_ELEMS) + 1;

  // --- configuration registers ---
  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.loop_count       <= 16'd1;
      cfg_q.output_count     <= 24'd1;
      cfg_q.relu_enable      <= 1'b0;
      cfg_q.weight_frac_bits <= 4'd7;
      cfg_q.input_frac_bits  <= 4'd0;
      cfg_q.output_frac_bits <= 4'd0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_LOOP_COUNT:       cfg_q.loop_count       <= cfg_i.data[15:0];
        CFG_OUTPUT_COUNT:     cfg_q.output_count     <= cfg_i.data;
        CFG_RELU_ENABLE:      cfg_q.relu_enable      <= cfg_i.data[0];
        CFG_WEIGHT_FRAC_BITS: cfg_q.weight_frac_bits <= cfg_i.data[3:0];
        CFG_INPUT_FRAC_BITS:  cfg_q.input_frac_bits  <= cfg_i.data[3:0];
        CFG_OUTPUT_FRAC_BITS: cfg_q.output_frac_bits <= cfg_i.data[3:0];
        default: ;
      endcase
    end
  end

  // --- stall chain, output side back to input side ---
  logic free1, free2, free3, free4;
  logic v1_q, v2, v3;

  assign free1      = !v1_q || free2;
  assign in_i.ready = free1;

  // --- stage 1: multiplier lanes ---
  logic signed [PROD_W-1:0] prod [VEC_ELEMS];
  logic signed [DATA_W-1:0] bias1_q;
  logic                     lane_en;

  assign lane_en = free1 && in_i.valid;

  for (genvar i = 0; i < VEC_ELEMS; i++) begin : g_lane
    if ((i + 1) * DATA_W <= VEC_BITS) begin : g_live
      cdpr_lane u_lane (
        .clk_i    (clk_i),
        .en_i     (lane_en),
        .data_i   ($signed(in_i.act_vec[i*DATA_W +: DATA_W])),
        .weight_i ($signed(in_i.weight_vec[i*DATA_W +: DATA_W])),
        .prod_o   (prod[i])
      );
    end else begin : g_pad
      // element lies past the operand word: contributes nothing
      assign prod[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (free1) begin
      v1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (lane_en) begin
      bias1_q <= in_i.bias_value;
    end
  end

  // --- stage 2: merge lanes into one dot product ---
  logic signed [SUM_W-1:0]  sum2;
  logic signed [DATA_W-1:0] bias2;

  cdpr_merge #(
    .VEC_ELEMS (VEC_ELEMS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .prod_i  (prod),
    .bias_i  (bias1_q),
    .free_i  (free3),
    .free_o  (free2),
    .valid_o (v2),
    .sum_o   (sum2),
    .bias_o  (bias2)
  );

  // --- stage 3: accumulate, count groups and outputs ---
  logic signed [ACC_WIDTH-1:0] acc3;
  logic signed [DATA_W-1:0]    bias3;
  logic                        last3;

  cdpr_accum #(
    .VEC_ELEMS (VEC_ELEMS),
    .ACC_WIDTH (ACC_WIDTH)
  ) u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (v2),
    .sum_i   (sum2),
    .bias_i  (bias2),
    .free_i  (free4),
    .free_o  (free3),
    .valid_o (v3),
    .acc_o   (acc3),
    .bias_o  (bias3),
    .last_o  (last3)
  );

  // --- stage 4: requantize into the output register ---
  cdpr_requant #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_requant (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (v3),
    .acc_i    (acc3),
    .bias_i   (bias3),
    .last_i   (last3),
    .ready_i  (out_o.ready),
    .free_o   (free4),
    .valid_o  (out_o.valid),
    .result_o (out_o.result_value),
    .last_o   (out_o.last_output)
  );

endmodule

### design/cdpr_lane.sv
// ----------------------------------------------------------------------------
// cdpr_lane
// One multiplier lane: registered signed 8x8 product of one element pair.
// ----------------------------------------------------------------------------
module cdpr_lane
  import cdpr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [DATA_W-1:0] data_i,
  input  logic signed [DATA_W-1:0] weight_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= data_i * weight_i;
    end
  end

  assign prod_o = prod_q;

endmodule

### design/cdpr_merge.sv
// ----------------------------------------------------------------------------
// cdpr_merge
// Sums the lane products into one dot product and registers it.
// ----------------------------------------------------------------------------
module cdpr_merge
  import cdpr_pkg::*;
#(
  parameter int VEC_ELEMS = DEF_VEC_ELEMS
) (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                valid_i,
  input  logic signed [PROD_W-1:0]                            prod_i [VEC_ELEMS],
  input  logic signed [DATA_W-1:0]                            bias_i,
  input  logic                                                free_i,
  output logic                                                free_o,
  output logic                                                valid_o,
  output logic signed [PROD_W+$clog2(VEC_ELEMS):0]            sum_o,
  output logic signed [DATA_W-1:0]                            bias_o
);

  localparam int SUM_W = PROD_W + $clog2(VEC_ELEMS) + 1;

  logic                    valid_q;
  logic signed [SUM_W-1:0] sum_d, sum_q;
  logic signed [DATA_W-1:0] bias_q;

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < VEC_ELEMS; i++) begin
      sum_d = sum_d + SUM_W'(prod_i[i]);
    end
  end

  assign free_o = !valid_q || free_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && valid_i) begin
      sum_q  <= sum_d;
      bias_q <= bias_i;
    end
  end

  assign valid_o = valid_q;
  assign sum_o   = sum_q;
  assign bias_o  = bias_q;

endmodule

### design/cdpr_accum.sv
// ----------------------------------------------------------------------------
// cdpr_accum
// Accumulator, group and run counters; hands a finished group downstream.
// ----------------------------------------------------------------------------
module cdpr_accum
  import cdpr_pkg::*;
#(
  parameter int VEC_ELEMS = DEF_VEC_ELEMS,
  parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  cfg_t                                     cfg_i,
  input  logic                                     valid_i,
  input  logic signed [PROD_W+$clog2(VEC_ELEMS):0] sum_i,
  input  logic signed [DATA_W-1:0]                 bias_i,
  input  logic                                     free_i,
  output logic                                     free_o,
  output logic                                     valid_o,
  output logic signed [ACC_WIDTH-1:0]              acc_o,
  output logic signed [DATA_W-1:0]                 bias_o,
  output logic                                     last_o
);

  localparam int SUM_W = PROD_W + $clog2(VEC_ELEMS) + 1;
  localparam int EXT_W = (SUM_W > ACC_WIDTH) ? SUM_W : ACC_WIDTH;

  logic [ACC_WIDTH-1:0]     acc_q, acc_d;
  logic signed [DATA_W-1:0] held_q, bias_use;
  logic [15:0]              inner_q;
  logic [23:0]              idx_q;
  logic                     valid_q;
  logic [ACC_WIDTH-1:0]     fin_acc_q;
  logic signed [DATA_W-1:0] fin_bias_q;
  logic                     fin_last_q;
  logic signed [EXT_W-1:0]  sum_x;
  logic                     first, grp_end, last, adv;
  logic [15:0]              lc_m1;
  logic [23:0]              oc_m1;

  assign free_o = !valid_q || free_i;
  assign adv    = valid_i && free_o;

  always_comb begin
    lc_m1    = cfg_i.loop_count - 16'd1;
    oc_m1    = cfg_i.output_count - 24'd1;
    first    = (inner_q == 16'd0);
    sum_x    = EXT_W'(sum_i);
    acc_d    = (first ? '0 : acc_q) + sum_x[ACC_WIDTH-1:0];
    bias_use = first ? bias_i : held_q;
    grp_end  = (inner_q == lc_m1);
    last     = (idx_q == oc_m1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      held_q  <= '0;
      inner_q <= '0;
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (free_o) begin
        valid_q <= valid_i && grp_end;
      end
      if (adv) begin
        acc_q   <= acc_d;
        held_q  <= bias_use;
        inner_q <= grp_end ? 16'd0 : inner_q + 16'd1;
        if (grp_end) begin
          idx_q <= last ? 24'd0 : idx_q + 24'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && grp_end) begin
      fin_acc_q  <= acc_d;
      fin_bias_q <= bias_use;
      fin_last_q <= last;
    end
  end

  assign valid_o = valid_q;
  assign acc_o   = $signed(fin_acc_q);
  assign bias_o  = fin_bias_q;
  assign last_o  = fin_last_q;

endmodule

### design/cdpr_requant.sv
// ----------------------------------------------------------------------------
// cdpr_requant
// Round, saturate, add shifted bias, optional ReLU; holds the result beat.
// ----------------------------------------------------------------------------
module cdpr_requant
  import cdpr_pkg::*;
#(
  parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cfg_t                        cfg_i,
  input  logic                        valid_i,
  input  logic signed [ACC_WIDTH-1:0] acc_i,
  input  logic signed [DATA_W-1:0]    bias_i,
  input  logic                        last_i,
  input  logic                        ready_i,
  output logic                        free_o,
  output logic                        valid_o,
  output logic signed [RES_W-1:0]     result_o,
  output logic                        last_o
);

  localparam logic signed [ACC_WIDTH:0] POS_LIM = 256;
  localparam logic signed [ACC_WIDTH:0] NEG_LIM = -256;

  logic signed [6:0]         s1_raw;
  logic signed [5:0]         s2_raw;
  logic [4:0]                s1;
  logic [3:0]                s2;
  logic signed [ACC_WIDTH:0] acc_x, t;
  logic signed [DATA_W-1:0]  bias_sh;
  logic signed [10:0]        u;
  logic signed [RES_W-1:0]   res;
  logic                      valid_q, last_q;
  logic signed [RES_W-1:0]   res_q;

  always_comb begin
    s1_raw  = $signed({3'b000, cfg_i.weight_frac_bits}) + $signed({3'b000, cfg_i.input_frac_bits})
              - $signed({3'b000, cfg_i.output_frac_bits}) - 7'sd1;
    s2_raw  = $signed({2'b00, cfg_i.weight_frac_bits}) - $signed({2'b00, cfg_i.output_frac_bits})
              - 6'sd1;
    s1      = s1_raw[6] ? 5'd0 : s1_raw[4:0];
    s2      = s2_raw[5] ? 4'd0 : s2_raw[3:0];
    acc_x   = {acc_i[ACC_WIDTH-1], acc_i};
    t       = (acc_x >>> s1) + (ACC_WIDTH+1)'(1);
    bias_sh = bias_i >>> s2;
    u       = $signed({2'b00, t[8:0]}) + 11'(bias_sh) + 11'sd1;
    if (t >= POS_LIM) begin
      res = 8'sh7f;
    end else if (t < NEG_LIM) begin
      res = -8'sd128;
    end else begin
      res = u[8:1];
    end
    if (cfg_i.relu_enable && res[7]) begin
      res = '0;
    end
  end

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && valid_i) begin
      res_q  <= res;
      last_q <= last_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;
  assign last_o   = last_q;

endmodule

### design/cdpr_checker.sv
// ----------------------------------------------------------------------------
// cdpr_port_checker
// Port-level checks on the conv dot product requantize unit, bound to the top.
// ----------------------------------------------------------------------------
`include "conv_dot_product_requantize_unit_macros.svh"

module cdpr_port_checker
  import cdpr_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  cdpr_in_if.sink    in_i,
  cdpr_out_if.source out_o,
  cdpr_cfg_if.sink   cfg_i
);

  // shadow of the ReLU enable register
  logic relu_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relu_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready && (cfg_i.index == CFG_RELU_ENABLE)) begin
      relu_q <= cfg_i.data[0];
    end
  end

  // a stalled result beat holds
  `CDPR_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid && $stable(out_o.result_value) && $stable(out_o.last_output))

  // input only backs up when the output is blocked
  `CDPR_ASSERT_IMPL(a_stall_source, !in_i.ready, out_o.valid && !out_o.ready)

  // ReLU never lets a negative result out
  `CDPR_ASSERT_IMPL(a_relu_sign, out_o.valid && relu_q, !out_o.result_value[RES_W-1])

endmodule

bind conv_dot_product_requantize_unit cdpr_port_checker u_cdpr_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o),
  .cfg_i  (cfg_i)
);

### verif/cdpr_checker.sv
// ----------------------------------------------------------------------------
// cdpr_checker
// Watches the operand, result and register channels of the requantize unit,
// keeps its own copy of the registers and the accumulation state, predicts
// each requantized output and compares result beats against it in order.
// ----------------------------------------------------------------------------
module cdpr_checker
  import cdpr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cdpr_in_if   in_mon,
  cdpr_out_if  out_mon,
  cdpr_cfg_if  cfg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  localparam int ACC_W = DEF_ACC_WIDTH;

  typedef struct packed {
    logic [RES_W-1:0] value;
    logic             last;
  } quant_res_t;

  quant_res_t               expected_q[$];
  cfg_t                     regs;
  logic [ACC_W-1:0]         acc_q;
  logic [15:0]              inner_q;
  logic [23:0]              run_pos_q;
  logic signed [DATA_W-1:0] bias_q;

  // signed byte-lane dot product; lanes past the 64-bit word count as zero
  function automatic int lane_dot(input logic [VEC_BITS-1:0] d, input logic [VEC_BITS-1:0] w);
    int sum;
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    sum = 0;
    for (int i = 0; i < DEF_VEC_ELEMS; i++) begin
      if ((i + 1) * DATA_W <= VEC_BITS) begin
        a = d[i*DATA_W +: DATA_W];
        b = w[i*DATA_W +: DATA_W];
        sum += int'(a) * int'(b);
      end
    end
    return sum;
  endfunction

  function automatic logic [RES_W-1:0] requantize(input logic [ACC_W-1:0] acc,
                                                  input logic signed [DATA_W-1:0] bias,
                                                  input cfg_t c);
    int sh_acc;
    int sh_bias;
    longint t;
    longint u;
    logic [RES_W-1:0] res;
    sh_acc  = int'(c.weight_frac_bits) + int'(c.input_frac_bits)
              - int'(c.output_frac_bits) - 1;
    sh_bias = int'(c.weight_frac_bits) - int'(c.output_frac_bits) - 1;
    if (sh_acc < 0) sh_acc = 0;
    if (sh_bias < 0) sh_bias = 0;
    t = (longint'($signed(acc)) >>> sh_acc) + 1;
    if (t >= 256) begin
      res = 8'h7F;
    end else if (t < -256) begin
      res = 8'h80;
    end else begin
      u   = (t & longint'(511)) + (longint'(bias) >>> sh_bias) + 1;
      res = RES_W'(u >>> 1);
    end
    if (c.relu_enable && res[RES_W-1]) res = '0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    quant_res_t       want;
    logic [RES_W-1:0] res;
    logic             last;
    int               new_fails;
    if (!rst_ni) begin
      regs.loop_count       = 16'd1;
      regs.output_count     = 24'd1;
      regs.relu_enable      = 1'b0;
      regs.weight_frac_bits = 4'd7;
      regs.input_frac_bits  = 4'd0;
      regs.output_frac_bits = 4'd0;
      acc_q                 = '0;
      inner_q               = '0;
      run_pos_q             = '0;
      bias_q                = '0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      new_fails = 0;

      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_idx_e'(cfg_mon.index))
          CFG_LOOP_COUNT:       regs.loop_count       = cfg_mon.data[15:0];
          CFG_OUTPUT_COUNT:     regs.output_count     = cfg_mon.data[23:0];
          CFG_RELU_ENABLE:      regs.relu_enable      = cfg_mon.data[0];
          CFG_WEIGHT_FRAC_BITS: regs.weight_frac_bits = cfg_mon.data[3:0];
          CFG_INPUT_FRAC_BITS:  regs.input_frac_bits  = cfg_mon.data[3:0];
          CFG_OUTPUT_FRAC_BITS: regs.output_frac_bits = cfg_mon.data[3:0];
          default: ;
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result beat: result_value %0d last_output %0b",
                 out_mon.result_value, out_mon.last_output);
          new_fails++;
        end else begin
          want = expected_q.pop_front();
          if (out_mon.result_value !== want.value) begin
            $error("result_value: expected %0d, got %0d",
                   $signed(want.value), out_mon.result_value);
            new_fails++;
          end
          if (out_mon.last_output !== want.last) begin
            $error("last_output: expected %0b, got %0b", want.last, out_mon.last_output);
            new_fails++;
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (inner_q == '0) begin
          acc_q  = '0;
          bias_q = in_mon.bias_value;
        end
        acc_q = acc_q + ACC_W'(lane_dot(in_mon.act_vec, in_mon.weight_vec));
        if (inner_q != 16'(regs.loop_count - 1'b1)) begin
          inner_q = inner_q + 1'b1;
        end else begin
          inner_q   = '0;
          res       = requantize(acc_q, bias_q, regs);
          last      = (run_pos_q == 24'(regs.output_count - 1'b1));
          run_pos_q = last ? '0 : run_pos_q + 1'b1;
          expected_q.push_back('{value: res, last: last});
        end
      end

      fail_count_o <= fail_count_o + new_fails;
      pending_o    <= expected_q.size();
    end
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Regression for the conv dot product requantize unit: directed operand beats
// at the rounding and saturation edges, randomized register settings and
// operands under three stall profiles, a long receiver hold-off, the corners
// of the output counter and a zero loop count. Checking is done by
// cdpr_checker; this module only drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import cdpr_pkg::*;

  // random beats per stall profile; about 850 beats in the whole run
  localparam int SECTION_BEATS = 250;
  // leave margin for the pipe to deliver the closing beat's result
  localparam int DRAIN_CYCLES  = 8;
  // receiver hold-off that backs the pipe up into in_i.ready; starts early
  // in the one-beat groups of the first phase, so every stage fills
  localparam int HOLD_AT_BEAT  = 2;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1_000_000;

  typedef enum int {
    MIX_RANDOM,   // full-range and small-magnitude lanes, lane extremes
    MIX_SATURATE  // mostly -128 x -128 lanes, the largest products
  } operand_mix_e;

  logic clk = 1'b0;
  logic rst_n;

  cdpr_in_if  in_bus ();
  cdpr_out_if out_bus ();
  cdpr_cfg_if cfg_bus ();

  int fail_count;
  int pending;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int in_beats    = 0;
  int out_beats   = 0;
  int reg_writes  = 0;
  int cycle_cnt   = 0;

  conv_dot_product_requantize_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .out_o  (out_bus),
    .cfg_i  (cfg_bus)
  );

  cdpr_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .cfg_mon      (cfg_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) in_beats <= in_beats + 1;
    if (out_bus.valid && out_bus.ready) out_beats <= out_beats + 1;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("conv_dot_product_requantize_unit regression: fail");
      $finish;
    end
  end

  // Result sink: random backpressure, plus one long hold-off once enough
  // operand beats went in. The sender keeps offering during the hold, so
  // every stage fills and in_i.ready has to drop.
  initial begin : result_sink
    int  hold_left;
    bit  hold_done;
    hold_left      = 0;
    hold_done      = 1'b0;
    out_bus.ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && in_beats >= HOLD_AT_BEAT) begin
        out_bus.ready <= 1'b0;
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // one lane byte: full range, small signed, an extreme, or zero
  function automatic logic [DATA_W-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'($urandom);
      4, 5, 6:    return DATA_W'($urandom_range(0, 7)) - 8'd4;
      7:          return 8'h80;
      8:          return 8'h7F;
      default:    return 8'h00;
    endcase
  endfunction

  function automatic logic [VEC_BITS-1:0] pick_vec();
    logic [VEC_BITS-1:0] v;
    if ($urandom_range(0, 2) == 0) begin
      v = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < VEC_BITS / DATA_W; i++) v[i*DATA_W +: DATA_W] = pick_byte();
    end
    return v;
  endfunction

  task automatic make_operands(input operand_mix_e mix, output logic [VEC_BITS-1:0] d,
                               output logic [VEC_BITS-1:0] w, output logic [DATA_W-1:0] b);
    if (mix == MIX_SATURATE && $urandom_range(0, 3) != 0) begin
      d = {8{8'h80}};
      w = {8{8'h80}};
    end else begin
      d = pick_vec();
      w = pick_vec();
    end
    b = DATA_W'($urandom);
  endtask

  // Directed beats, checked against the reset shifts (6 and 6): zero,
  // both saturation signs, the small-negative rounding path, and the four
  // boundary points of the saturation window (t = 256, 255, -256, -257).
  task automatic directed_operands(input int k, output logic [VEC_BITS-1:0] d,
                                   output logic [VEC_BITS-1:0] w, output logic [DATA_W-1:0] b);
    case (k)
      0:       begin d = '0;                    w = '0;                    b = 8'h00; end
      1:       begin d = {8{8'h80}};            w = {8{8'h80}};            b = 8'h7F; end
      2:       begin d = {8{8'h80}};            w = {8{8'h7F}};            b = 8'h80; end
      3:       begin d = {8{8'h7F}};            w = {8{8'h7F}};            b = 8'h80; end
      4:       begin d = {8{8'hFF}};            w = {8{8'h01}};            b = 8'h80; end
      5:       begin d = {8{8'hFF}};            w = {8{8'hFF}};            b = 8'h7F; end
      6:       begin d = 64'h0000_0000_0000_0880; w = 64'h0000_0000_0000_0881; b = 8'h7F; end
      7:       begin d = 64'h0000_0000_00FF_0880; w = 64'h0000_0000_0001_0881; b = 8'h80; end
      8:       begin d = 64'h0000_0000_0000_1080; w = 64'h0000_0000_0000_F47F; b = 8'h7F; end
      default: begin d = 64'h0000_0000_0001_1080; w = 64'h0000_0000_00FF_F47F; b = 8'h80; end
    endcase
  endtask

  // One operand beat. valid is lowered only for a sender gap, so a
  // back-to-back beat keeps valid high with a single assignment.
  task automatic push_operands(input logic [VEC_BITS-1:0] d, input logic [VEC_BITS-1:0] w,
                               input logic [DATA_W-1:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.act_vec    <= d;
    in_bus.weight_vec <= w;
    in_bus.bias_value <= b;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Stop sending, wait for every predicted output, then let beats that
  // close no group clear the pipe before registers may change.
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // cfg valid stays high across a burst and drops after the last write
  task automatic write_reg(input cfg_idx_e idx, input int value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    reg_writes++;
  endtask

  task automatic program_regs(input int loop_n, input int ocnt, input bit relu,
                              input int fw, input int fi, input int fo);
    write_reg(CFG_LOOP_COUNT, loop_n);
    write_reg(CFG_OUTPUT_COUNT, ocnt);
    write_reg(CFG_RELU_ENABLE, relu);
    write_reg(CFG_WEIGHT_FRAC_BITS, fw);
    write_reg(CFG_INPUT_FRAC_BITS, fi);
    write_reg(CFG_OUTPUT_FRAC_BITS, fo);
    cfg_bus.valid <= 1'b0;
  endtask

  // loop_n of zero means a 64k-beat group
  task automatic run_groups(input int loop_n, input int groups, input operand_mix_e mix);
    int                  span;
    logic [VEC_BITS-1:0] d;
    logic [VEC_BITS-1:0] w;
    logic [DATA_W-1:0]   b;
    span = (loop_n == 0) ? 65536 : loop_n;
    repeat (span * groups) begin
      make_operands(mix, d, w, b);
      push_operands(d, w, b);
    end
  endtask

  // Run that leaves the output index off a run boundary (index past the
  // output count, or counts that never mark last within reach), then
  // close it: with the index known, one extra group hits last and the
  // index is back at zero for the next phase.
  task automatic open_run(input int loop_n, input int ocnt, input int groups,
                          input int start_pos, input bit relu, input int fw,
                          input int fi, input int fo, input operand_mix_e mix);
    program_regs(loop_n, ocnt, relu, fw, fi, fo);
    run_groups(loop_n, groups, mix);
    settle();
    program_regs(1, start_pos + groups + 1, relu, fw, fi, fo);
    run_groups(1, 1, MIX_RANDOM);
    settle();
  endtask

  // Random phases: fresh settings each time, whole runs only, so the
  // output index is back at zero when the phase ends.
  task automatic random_section(input int target);
    int sent;
    int loop_n;
    int ocnt;
    int runs;
    sent = 0;
    while (sent < target) begin
      loop_n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 16) : $urandom_range(1, 4);
      ocnt   = $urandom_range(1, 5);
      runs   = 40 / (loop_n * ocnt);
      if (runs == 0) runs = 1;
      program_regs(loop_n, ocnt, $urandom_range(0, 1), $urandom_range(0, 15),
                   $urandom_range(0, 15), $urandom_range(0, 15));
      run_groups(loop_n, ocnt * runs, MIX_RANDOM);
      sent += loop_n * ocnt * runs;
      settle();
    end
  endtask

  initial begin : stimulus
    logic [VEC_BITS-1:0] d;
    logic [VEC_BITS-1:0] w;
    logic [DATA_W-1:0]   b;

    in_bus.valid      = 1'b0;
    in_bus.act_vec    = '0;
    in_bus.weight_vec = '0;
    in_bus.bias_value = '0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    rst_n             = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset register values: one beat per group, every output is last
    for (int k = 0; k < 10; k++) begin
      directed_operands(k, d, w, b);
      push_operands(d, w, b);
    end
    settle();

    // both shift counts negative (clamped), ReLU on, pairs of beats,
    // runs of three; four groups leave the output index at one
    program_regs(2, 3, 1'b1, 0, 0, 15);
    for (int k = 0; k < 8; k++) begin
      directed_operands(k, d, w, b);
      push_operands(d, w, ~b);
    end
    settle();

    // output count no larger than the current index: index counts on; largest shifts
    open_run(1, 1, 3, 1, 1'b0, 15, 15, 0, MIX_RANDOM);

    // receiver idles more than sender, then the reverse, then neither
    tx_idle_pct <= 32;
    rx_idle_pct <= 72;
    random_section(SECTION_BEATS);
    tx_idle_pct <= 72;
    rx_idle_pct <= 32;
    random_section(SECTION_BEATS);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    random_section(SECTION_BEATS);

    // zero output count marks last only at index 0xFFFFFF; max count likewise far off
    open_run(1, 0, 6, 0, $urandom_range(0, 1), $urandom_range(0, 15),
             $urandom_range(0, 15), $urandom_range(0, 15), MIX_RANDOM);
    open_run(2, 24'hFFFFFF, 4, 0, $urandom_range(0, 1), $urandom_range(0, 15),
             $urandom_range(0, 15), $urandom_range(0, 15), MIX_RANDOM);

    // zero loop count is a 64k-beat group: a short partial group stays silent
    program_regs(0, 1, 1'b0, 7, 0, 0);
    repeat (24) begin
      make_operands(MIX_SATURATE, d, w, b);
      push_operands(d, w, b);
    end
    settle();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operand beats, %0d result beats, %0d register writes",
             in_beats, out_beats, reg_writes);
    $display("loop counts 0 to 16, output counts 0/1/max, clamped and max shifts, relu, stalls");
    if (fail_count == 0 && pending == 0) begin
      $display("conv_dot_product_requantize_unit regression: pass");
    end else begin
      $display("conv_dot_product_requantize_unit regression: fail");
    end
    $finish;
  end

endmodule

### files.f
+incdir+design
design/cdpr_pkg.sv
design/cdpr_if.sv
design/cdpr_lane.sv
design/cdpr_merge.sv
design/cdpr_accum.sv
design/cdpr_requant.sv
design/conv_dot_product_requantize_unit.sv
design/cdpr_checker.sv
verif/cdpr_checker.sv
verif/tb.sv
